// ----- rtl/core/dda_pkg.sv -----
// ============================================================================
// dda_pkg
// Shared types and constants for the DDA line pixel generator.
// ============================================================================
`default_nettype none

package dda_pkg;

    localparam int unsigned COORD_W   = 19;   // unsigned fixed-point coordinate
    localparam int unsigned PIX_W     = 11;   // integer pixel coordinate
    localparam int unsigned COLOR_W   = 32;
    localparam int unsigned ACC_FRAC  = 16;   // fraction bits of the position
    localparam int unsigned ACC_W     = 27;   // Q11.16 position accumulator
    localparam int unsigned INC_W     = 18;   // signed Q1.16 increment
    localparam int unsigned QUO_W     = 17;   // unsigned quotient, at most 1.0
    localparam int unsigned DIV_STEPS = QUO_W;
    localparam int unsigned DIV_CNT_W = 5;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hffff000f;

    // Controller to datapath
    typedef struct packed {
        logic load_in;     // capture endpoints and form deltas
        logic setup;       // select major delta
        logic init;        // load step count, position and divider
        logic div_step;    // one restoring-division step
        logic div_first;   // first step compares without shifting
        logic advance;     // step position, count down
    } dda_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic zero_len;    // integer part of major delta is zero
        logic last;        // one pixel left
    } dda_status_t;

endpackage : dda_pkg

`default_nettype wire

// ----- rtl/core/dda_ctrl.sv -----
// ============================================================================
// dda_ctrl
// Sequencer: capture, setup, length check, division, pixel walk.
// ============================================================================
`default_nettype none

module dda_ctrl
    import dda_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire dda_status_t status,
    output dda_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.init     = 1'b1;
                div_cnt_next = '0;
                state_next   = status.zero_len ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_first = (div_cnt_reg == '0);
                div_cnt_next  = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    cmd.advance = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule : dda_ctrl

`default_nettype wire

// ----- rtl/core/dda_dp.sv -----
// ============================================================================
// dda_dp
// Datapath: deltas, step count, two restoring dividers, position walk.
// ============================================================================
`default_nettype none

module dda_dp
    import dda_pkg::*;
#(
    parameter int unsigned MAX_STEPS = 64,
    parameter int unsigned FRAC_BITS = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dda_cmd_t           cmd,
    output dda_status_t             status,
    input  wire logic               cfg_we,
    input  wire logic [COLOR_W-1:0] cfg_wdata,
    input  wire logic [COORD_W-1:0] start_x,
    input  wire logic [COORD_W-1:0] start_y,
    input  wire logic [COORD_W-1:0] end_x,
    input  wire logic [COORD_W-1:0] end_y,
    output logic [PIX_W-1:0]        pixel_x,
    output logic [PIX_W-1:0]        pixel_y,
    output logic [COLOR_W-1:0]      pixel_color,
    output logic                    last_pixel,
    output logic                    truncated
);

    localparam int unsigned STEP_W = $clog2(MAX_STEPS + 1);
    localparam int unsigned POS_SH = ACC_FRAC - FRAC_BITS;
    localparam logic [COORD_W-1:0] MAX_CNT = COORD_W'(MAX_STEPS);

    logic [COLOR_W-1:0] color_reg;
    logic [COORD_W-1:0] sx_reg, sy_reg, ax_reg, ay_reg, m_reg;
    logic               nx_reg, ny_reg;
    logic [COORD_W-1:0] rem_x_reg, rem_y_reg;
    logic [QUO_W-1:0]   q_x_reg, q_y_reg;
    logic [ACC_W-1:0]   pos_x_reg, pos_y_reg;
    logic [STEP_W-1:0]  steps_left_reg;
    logic               trunc_reg;

    logic [COORD_W-1:0] count;
    logic               sat;
    logic [COORD_W:0]   trial_x, trial_y;
    logic               ge_x, ge_y;
    logic [INC_W-1:0]   inc_x, inc_y;

    // Step count from the major delta, saturated
    assign count = m_reg >> FRAC_BITS;
    assign sat   = (count > MAX_CNT);

    assign status.zero_len = (count == '0);
    assign status.last     = (steps_left_reg == STEP_W'(1));

    // Divider trial: first step compares the magnitude itself
    assign trial_x = cmd.div_first ? {1'b0, rem_x_reg} : {rem_x_reg, 1'b0};
    assign trial_y = cmd.div_first ? {1'b0, rem_y_reg} : {rem_y_reg, 1'b0};
    assign ge_x    = (trial_x >= {1'b0, m_reg});
    assign ge_y    = (trial_y >= {1'b0, m_reg});

    // Apply sign after the unsigned quotient
    assign inc_x = nx_reg ? INC_W'(-{1'b0, q_x_reg}) : {1'b0, q_x_reg};
    assign inc_y = ny_reg ? INC_W'(-{1'b0, q_y_reg}) : {1'b0, q_y_reg};

    assign pixel_x     = pos_x_reg[ACC_FRAC +: PIX_W];
    assign pixel_y     = pos_y_reg[ACC_FRAC +: PIX_W];
    assign pixel_color = color_reg;
    assign last_pixel  = status.last;
    assign truncated   = trunc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg      <= COLOR_RESET;
            steps_left_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
            if (cmd.init)
            begin
                steps_left_reg <= sat ? STEP_W'(MAX_STEPS) : count[STEP_W-1:0];
            end
            else if (cmd.advance)
            begin
                steps_left_reg <= steps_left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sx_reg <= start_x;
            sy_reg <= start_y;
            nx_reg <= (end_x < start_x);
            ny_reg <= (end_y < start_y);
            ax_reg <= (end_x < start_x) ? start_x - end_x : end_x - start_x;
            ay_reg <= (end_y < start_y) ? start_y - end_y : end_y - start_y;
        end
        if (cmd.setup)
        begin
            m_reg <= (ax_reg < ay_reg) ? ay_reg : ax_reg;
        end
        if (cmd.init)
        begin
            trunc_reg <= sat;
            rem_x_reg <= ax_reg;
            rem_y_reg <= ay_reg;
            q_x_reg   <= '0;
            q_y_reg   <= '0;
            pos_x_reg <= ACC_W'({{ACC_FRAC{1'b0}}, sx_reg} << POS_SH);
            pos_y_reg <= ACC_W'({{ACC_FRAC{1'b0}}, sy_reg} << POS_SH);
        end
        else if (cmd.div_step)
        begin
            rem_x_reg <= ge_x ? COORD_W'(trial_x - {1'b0, m_reg}) : trial_x[COORD_W-1:0];
            rem_y_reg <= ge_y ? COORD_W'(trial_y - {1'b0, m_reg}) : trial_y[COORD_W-1:0];
            q_x_reg   <= {q_x_reg[QUO_W-2:0], ge_x};
            q_y_reg   <= {q_y_reg[QUO_W-2:0], ge_y};
        end
        else if (cmd.advance)
        begin
            pos_x_reg <= pos_x_reg + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
            pos_y_reg <= pos_y_reg + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
        end
    end

endmodule : dda_dp

`default_nettype wire

// ----- rtl/core/dda_line_pixel_generator.sv -----
// ============================================================================
// dda_line_pixel_generator
// DDA line rasterizer: one line request in, one pixel word per step out.
// ============================================================================
//
//  channel   direction  handshake          payload
//  --------  ---------  -----------------  ---------------------------------
//  s_*       in         tvalid / tready    start_x, start_y, end_x, end_y
//  m_*       out        tvalid / tready    pixel_x, pixel_y, pixel_color;
//                                          tlast = last_pixel, tuser = truncated
//  cfg_*     in         write enable       line_color
//
//  Sequence: after acceptance the block selects the major delta, checks the
//  length, runs the bit-per-cycle restoring dividers, then sends one pixel
//  word per cycle while m_tready is high; the sequencer is idle again in the
//  cycle after the last word leaves. A line shorter than one pixel returns
//  to idle after the length check and emits nothing.
//  One line is worked at a time: s_tready is high only while idle.
//  Reset clears the sequencer and the step count and loads line_color with
//  0xffff000f. A stalled pixel word holds its fields until m_tready is seen,
//  but for pixel_color, which follows any cfg_we write.
`default_nettype none

module dda_line_pixel_generator
    import dda_pkg::*;
#(
    parameter int unsigned MAX_STEPS = 64,
    parameter int unsigned FRAC_BITS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // start_x[18:0], start_y[37:19], end_x[56:38], end_y[75:57], zero pad
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pixel_x[10:0], pixel_y[21:11], pixel_color[53:22], zero pad
    output logic [55:0]      m_tdata,
    // truncated[0]
    output logic [0:0]       m_tuser,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    dda_cmd_t           cmd;
    dda_status_t        status;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
    logic               truncated;

    // Sequencer: owns both handshakes
    dda_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic and line state
    dda_dp #(
        .MAX_STEPS (MAX_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .start_x     (s_tdata[18:0]),
        .start_y     (s_tdata[37:19]),
        .end_x       (s_tdata[56:38]),
        .end_y       (s_tdata[75:57]),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel),
        .truncated   (truncated)
    );

    // Pack the pixel word, pad to whole bytes
    assign m_tdata = {2'b00, pixel_color, pixel_y, pixel_x};
    assign m_tuser = truncated;
    assign m_tlast = last_pixel;

    // Never take a request while a pixel word is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while pixels pending");

    // A request always starts the setup sequence
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready && !m_tvalid)
        else $error("sequencer did not leave idle after accept");

    // The last pixel word closes the line
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
        else $error("pixels continued after last");

    // Pixel walk never starts directly from idle
    a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("pixel word without division");

endmodule : dda_line_pixel_generator

`default_nettype wire
